[hdl/palindromic_tree_builder_defines.svh]
// ============================================================================
// Assertion macros for the palindromic tree builder
// Concurrent checks that compile away in synthesis.
// ============================================================================
`ifndef PALINDROMIC_TREE_BUILDER_DEFINES_SVH
`define PALINDROMIC_TREE_BUILDER_DEFINES_SVH

`ifndef SYNTHESIS
`define PTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("palindromic tree builder check failed");
`define PTB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("palindromic tree builder check failed");
`else
`define PTB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/ptb_pkg.sv]
// ============================================================================
// Palindromic tree builder package
// Shared constants, state type and control and status structs.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;

  localparam int SYMBOL_W    = 5;
  localparam int OUT_LEN_W   = 11;
  localparam int OUT_START_W = 10;
  localparam int OUT_NODE_W  = 11;
  localparam int OUT_CNT_W   = 11;
  localparam int OUT_DIST_W  = 11;
  localparam int OUT_TOTAL_W = 20;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 80;

  localparam int EPOCH_W    = 4;
  localparam int IMAG_ROOT  = 1;
  localparam int EMPTY_ROOT = 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NODE_RD,
    S_NODE_CHK,
    S_TXT_CHK,
    S_CHILD_WAIT,
    S_CHILD_CHK,
    S_HIT_RD,
    S_HIT_CHK,
    S_LNK_RD,
    S_LNK_CHK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic new_string;
  } child_ctrl_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } child_stat_t;

endpackage

`default_nettype wire

[hdl/ptb_child_table.sv]
// ============================================================================
// Palindromic tree child table
// Edge memory tagged with a string epoch, with a clearing pass on reset and on wrap.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ptb_child_table #(
  parameter int DEPTH  = 26702,
  parameter int AW     = 15,
  parameter int NODE_W = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ptb_pkg::child_ctrl_t ctrl,
  input  wire logic [AW-1:0]        rd_addr,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [NODE_W-1:0]    wr_node,
  output logic [NODE_W-1:0]         rd_node,
  output ptb_pkg::child_stat_t      stat
);
  import ptb_pkg::*;

  localparam int WORD_W = EPOCH_W + NODE_W;

  logic [WORD_W-1:0]  mem [DEPTH];
  logic [WORD_W-1:0]  q_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic               clearing_r;
  logic [AW-1:0]      clr_addr_r;

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (ctrl.wr_en) begin
      mem[wr_addr] <= {epoch_r, wr_node};
    end
    q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      epoch_r    <= EPOCH_W'(1);
    end else if (clearing_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end else if (ctrl.new_string) begin
      if (epoch_r == '1) begin
        epoch_r    <= EPOCH_W'(1);
        clearing_r <= 1'b1;
        clr_addr_r <= '0;
      end else begin
        epoch_r <= epoch_r + EPOCH_W'(1);
      end
    end
  end

  assign rd_node   = q_r[NODE_W-1:0];
  assign stat.hit  = (q_r[WORD_W-1 -: EPOCH_W] == epoch_r);
  assign stat.busy = clearing_r;

endmodule

`default_nettype wire

[hdl/palindromic_tree_builder.sv]
// ============================================================================
// Palindromic tree builder
// Online eertree construction, one symbol per input transaction.
// ============================================================================
// Each input transaction carries a symbol in in_tdata[4:0] and the end of a
// string in in_tlast. Each one yields exactly one output transaction with the
// longest palindromic suffix, its node, the suffix count, the distinct count
// and the running total of palindromic occurrences.
// A symbol whose previous suffix extends at once passes node read, node
// check, text check, child wait, child check and the read of the hit node.
// Each suffix-link step repeats node read and check, and text check unless
// the text is too short. A new single-letter node needs no second walk; a
// longer one walks the links again, then reads its link and writes its count.
// A dropped symbol goes straight to the result. One item is processed at a
// time; the next input is accepted as soon as the result is loaded into the
// output register, even if that register still waits for out_tready. A
// stalled receiver holds the block in its last state. After reset, and after
// every fifteenth end of string, all (MAX_LEN+3)*ALPHABET child table entries
// are swept with in_tready low. End of string clears the tree after its
// result is formed. Symbols past MAX_LEN are dropped and flagged as overflow.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "palindromic_tree_builder_defines.svh"

module palindromic_tree_builder #(
  parameter int MAX_LEN  = ptb_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = ptb_pkg::ALPHABET_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // symbol[4:0], zero padding[7:5]
  input  wire logic [ptb_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            in_tlast,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // new_palindrome[0], suffix_length[11:1], suffix_start[21:12],
  // node_index[32:22], suffix_count[43:33], distinct_palindromes[54:44],
  // total_palindromes[74:55], overflow[75], zero padding[79:76]
  output logic [ptb_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import ptb_pkg::*;

  localparam int NODES       = MAX_LEN + 3;
  localparam int NODE_W      = $clog2(NODES);
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int TXT_AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SYM_W       = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
  localparam int CHILD_DEPTH = NODES * ALPHABET;
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
  localparam int NW          = LEN_W + NODE_W + LEN_W;

  state_t state_r, state_nxt;

  logic [SYM_W-1:0]       sym_r;
  logic                   eos_r;
  logic                   ovf_r;
  logic [LEN_W-1:0]       pos_r;
  logic [NODE_W-1:0]      last_node_r;
  logic [NODE_W-1:0]      node_count_r;
  logic [OUT_TOTAL_W-1:0] total_r;
  logic [NODE_W-1:0]      walk_r;
  logic                   phase_b_r;
  logic [LEN_W-1:0]       len_r;
  logic [NODE_W-1:0]      link_r;
  logic                   cur_imag_r;
  logic [LEN_W-1:0]       cur_len_r;
  logic [NODE_W-1:0]      cur_link_r;
  logic [NODE_W-1:0]      nd_r;
  logic [LEN_W-1:0]       nd_len_r;
  logic [NODE_W-1:0]      nd_link_r;
  logic [LEN_W-1:0]       res_cnt_r;
  logic                   created_r;
  logic [CHILD_AW-1:0]    child_addr_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [NW-1:0]     node_mem [NODES];
  logic [NW-1:0]     node_q_r;
  logic [SYM_W-1:0]  text_mem [MAX_LEN];
  logic [SYM_W-1:0]  text_q_r;

  logic              in_accept;
  logic              out_free;
  logic [31:0]       sym32;
  logic [SYM_W-1:0]  sym_sat;
  logic              pos_full;
  logic              walk_imag;
  logic [LEN_W-1:0]  w_len;
  logic [NODE_W-1:0] w_link;
  logic              too_short;
  logic              txt_match;
  logic              fit;
  logic [LEN_W-1:0]  fit_len;
  logic [NODE_W-1:0] fit_link;
  logic [NODE_W-1:0] new_node;
  logic [NODE_W-1:0] child_node;

  logic [NODE_W-1:0] node_rd_addr;
  logic              node_we;
  logic [NODE_W-1:0] node_wr_addr;
  logic [NW-1:0]     node_wdata;
  logic              text_we;
  logic [TXT_AW-1:0] text_rd_addr;

  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic [LEN_W-1:0]       res_len;
  logic [LEN_W-1:0]       res_start;
  logic [NODE_W-1:0]      res_node;
  logic [LEN_W-1:0]       res_cnt;
  logic [OUT_TOTAL_W-1:0] total_nxt;

  child_ctrl_t cctrl;
  child_stat_t cstat;

  assign in_tready  = (state_r == S_IDLE) && !cstat.busy;
  assign in_accept  = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sym32   = 32'(in_tdata[SYMBOL_W-1:0]);
  assign sym_sat = SYM_W'((sym32 >= ALPHABET) ? (ALPHABET - 1) : sym32);
  assign pos_full = (32'(pos_r) >= MAX_LEN);

  assign walk_imag = (walk_r == NODE_W'(IMAG_ROOT));
  assign w_len     = (walk_r == NODE_W'(EMPTY_ROOT)) ? '0 : node_q_r[NW-1 -: LEN_W];
  assign w_link    = (walk_r <= NODE_W'(EMPTY_ROOT)) ? NODE_W'(IMAG_ROOT)
                                                     : node_q_r[LEN_W +: NODE_W];
  assign too_short = (pos_r <= w_len);
  assign txt_match = (text_q_r == sym_r);
  assign fit       = ((state_r == S_NODE_CHK) && walk_imag) ||
                     ((state_r == S_TXT_CHK) && txt_match);
  assign fit_len   = (state_r == S_NODE_CHK) ? '0 : len_r;
  assign fit_link  = (state_r == S_NODE_CHK) ? NODE_W'(IMAG_ROOT) : link_r;
  assign new_node  = node_count_r + NODE_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = pos_full ? S_FINISH : S_NODE_RD;
        end
      end
      S_NODE_RD: state_nxt = S_NODE_CHK;
      S_NODE_CHK: begin
        if (walk_imag) begin
          state_nxt = S_CHILD_WAIT;
        end else if (too_short) begin
          state_nxt = S_NODE_RD;
        end else begin
          state_nxt = S_TXT_CHK;
        end
      end
      S_TXT_CHK: state_nxt = txt_match ? S_CHILD_WAIT : S_NODE_RD;
      S_CHILD_WAIT: state_nxt = S_CHILD_CHK;
      S_CHILD_CHK: begin
        if (phase_b_r) begin
          state_nxt = S_LNK_RD;
        end else if (cstat.hit) begin
          state_nxt = S_HIT_RD;
        end else if (cur_imag_r) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_NODE_RD;
        end
      end
      S_HIT_RD:  state_nxt = S_HIT_CHK;
      S_HIT_CHK: state_nxt = S_FINISH;
      S_LNK_RD:  state_nxt = S_LNK_CHK;
      S_LNK_CHK: state_nxt = S_FINISH;
      S_FINISH:  state_nxt = out_free ? S_IDLE : S_FINISH;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Memory controls.
  always_comb begin
    node_rd_addr     = walk_r;
    node_we          = 1'b0;
    node_wr_addr     = nd_r;
    node_wdata       = {nd_len_r, nd_link_r, LEN_W'(node_q_r[0 +: LEN_W] + LEN_W'(1))};
    text_we          = 1'b0;
    text_rd_addr     = TXT_AW'(pos_r - LEN_W'(1) - w_len);
    cctrl.wr_en      = 1'b0;
    cctrl.new_string = 1'b0;
    unique case (state_r)
      S_IDLE: text_we = in_accept && !pos_full;
      S_HIT_RD: node_rd_addr = nd_r;
      S_LNK_RD: node_rd_addr = nd_link_r;
      S_CHILD_CHK: begin
        if (!phase_b_r && !cstat.hit) begin
          cctrl.wr_en = 1'b1;
          if (cur_imag_r) begin
            node_we      = 1'b1;
            node_wr_addr = new_node;
            node_wdata   = {LEN_W'(1), NODE_W'(EMPTY_ROOT), LEN_W'(1)};
          end
        end
      end
      S_LNK_CHK: node_we = 1'b1;
      S_FINISH: cctrl.new_string = out_free && eos_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wr_addr] <= node_wdata;
    end
    node_q_r <= node_mem[node_rd_addr];
    if (text_we) begin
      text_mem[pos_r[TXT_AW-1:0]] <= sym_sat;
    end
    text_q_r <= text_mem[text_rd_addr];
  end

  ptb_child_table #(
    .DEPTH  (CHILD_DEPTH),
    .AW     (CHILD_AW),
    .NODE_W (NODE_W)
  ) u_child (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (cctrl),
    .rd_addr (child_addr_r),
    .wr_addr (child_addr_r),
    .wr_node (new_node),
    .rd_node (child_node),
    .stat    (cstat)
  );

  // Result assembly.
  always_comb begin
    res_len   = ovf_r ? '0 : nd_len_r;
    res_start = ovf_r ? '0 : (pos_r + LEN_W'(1) - nd_len_r);
    res_node  = ovf_r ? '0 : nd_r;
    res_cnt   = ovf_r ? '0 : res_cnt_r;
    total_nxt = total_r + OUT_TOTAL_W'(res_cnt);
    out_data_nxt = '0;
    out_data_nxt[0]     = created_r && !ovf_r;
    out_data_nxt[11:1]  = OUT_LEN_W'(res_len);
    out_data_nxt[21:12] = OUT_START_W'(res_start);
    out_data_nxt[32:22] = OUT_NODE_W'(res_node);
    out_data_nxt[43:33] = OUT_CNT_W'(res_cnt);
    out_data_nxt[54:44] = OUT_DIST_W'(node_count_r - NODE_W'(EMPTY_ROOT));
    out_data_nxt[74:55] = total_nxt;
    out_data_nxt[75]    = ovf_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_r        <= '0;
      last_node_r  <= NODE_W'(EMPTY_ROOT);
      node_count_r <= NODE_W'(EMPTY_ROOT);
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_CHILD_CHK) && !phase_b_r && !cstat.hit) begin
        node_count_r <= new_node;
      end
      if ((state_r == S_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
        if (eos_r) begin
          pos_r        <= '0;
          last_node_r  <= NODE_W'(EMPTY_ROOT);
          node_count_r <= NODE_W'(EMPTY_ROOT);
          total_r      <= '0;
        end else if (!ovf_r) begin
          pos_r       <= pos_r + LEN_W'(1);
          last_node_r <= nd_r;
          total_r     <= total_nxt;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          sym_r     <= sym_sat;
          eos_r     <= in_tlast;
          ovf_r     <= pos_full;
          walk_r    <= last_node_r;
          phase_b_r <= 1'b0;
          created_r <= 1'b0;
        end
      end
      S_NODE_CHK: begin
        len_r  <= w_len;
        link_r <= w_link;
        if (!walk_imag && too_short) begin
          walk_r <= w_link;
        end
      end
      S_TXT_CHK: begin
        if (!txt_match) begin
          walk_r <= link_r;
        end
      end
      S_CHILD_CHK: begin
        if (phase_b_r) begin
          nd_link_r <= child_node;
        end else if (cstat.hit) begin
          nd_r <= child_node;
        end else begin
          nd_r      <= new_node;
          created_r <= 1'b1;
          nd_len_r  <= cur_imag_r ? LEN_W'(1) : (cur_len_r + LEN_W'(2));
          res_cnt_r <= LEN_W'(1);
          phase_b_r <= !cur_imag_r;
          walk_r    <= cur_link_r;
        end
      end
      S_HIT_CHK: begin
        nd_len_r  <= node_q_r[NW-1 -: LEN_W];
        res_cnt_r <= node_q_r[0 +: LEN_W];
      end
      S_LNK_CHK: res_cnt_r <= node_q_r[0 +: LEN_W] + LEN_W'(1);
      S_FINISH: begin
        if (out_free) begin
          out_data_r <= out_data_nxt;
        end
      end
      default: ;
    endcase
    if (fit) begin
      child_addr_r <= CHILD_AW'(int'(walk_r) * ALPHABET + int'(sym_r));
      if (!phase_b_r) begin
        cur_imag_r <= (state_r == S_NODE_CHK);
        cur_len_r  <= fit_len;
        cur_link_r <= fit_link;
      end
    end
  end

  `PTB_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, in_tready, !cstat.busy)
  `PTB_ASSERT_IMP(a_no_edge_write_in_clear, clk, rst_n, cstat.busy, !cctrl.wr_en)
  `PTB_ASSERT_NXT(a_accept_starts_work, clk, rst_n, in_accept, state_r != S_IDLE)
  `PTB_ASSERT_IMP(a_node_count_bound, clk, rst_n, 1'b1, node_count_r <= NODE_W'(MAX_LEN + 2))

endmodule

`default_nettype wire
